>>> design/lmgp_pkg.sv
// Shared types and constants of the LED meter gradient painter.
// Holds the stop reset colors, the slot-to-pixel order table and run sizes.
// Depends on nothing.
package lmgp_pkg;

	localparam int PIXEL_COUNT = 25;
	localparam int ADDR_W      = 5;
	localparam int LEVEL_W     = 8;
	localparam int STEP_W      = 6;                      // counts 0 .. 2*PIXEL_COUNT-1
	localparam int CHAN_W      = 8;
	localparam int RGB_W       = 3 * CHAN_W;
	localparam int CFG_IDX_W   = 2;

	typedef logic [RGB_W-1:0]  rgb_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ZERO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TWO   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_THREE = 2'd3;

	localparam rgb_t STOP_ZERO_RST  = 24'h000000;
	localparam rgb_t STOP_ONE_RST   = 24'h0069FF;
	localparam rgb_t STOP_TWO_RST   = 24'hD200AA;
	localparam rgb_t STOP_THREE_RST = 24'hFF3C23;

	localparam logic [STEP_W-1:0]  LAST_BLACK_STEP = STEP_W'(PIXEL_COUNT - 1);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(PIXEL_COUNT);
	localparam logic [ADDR_W-1:0]  LAST_SLOT       = ADDR_W'(PIXEL_COUNT - 1);

	// gradient segment select
	typedef enum logic [1:0] {
		SEG_LOW  = 2'd0,
		SEG_MID  = 2'd1,
		SEG_HIGH = 2'd2,
		SEG_END  = 2'd3
	} seg_t;

	// scattered order in which slots light up
	function automatic logic [ADDR_W-1:0] slot_to_pixel(input logic [ADDR_W-1:0] slot);
		logic [ADDR_W-1:0] pix;
		case (slot)
			5'd0:    pix = 5'd12;
			5'd1:    pix = 5'd0;
			5'd2:    pix = 5'd24;
			5'd3:    pix = 5'd4;
			5'd4:    pix = 5'd20;
			5'd5:    pix = 5'd7;
			5'd6:    pix = 5'd17;
			5'd7:    pix = 5'd11;
			5'd8:    pix = 5'd13;
			5'd9:    pix = 5'd2;
			5'd10:   pix = 5'd22;
			5'd11:   pix = 5'd6;
			5'd12:   pix = 5'd8;
			5'd13:   pix = 5'd16;
			5'd14:   pix = 5'd18;
			5'd15:   pix = 5'd1;
			5'd16:   pix = 5'd3;
			5'd17:   pix = 5'd5;
			5'd18:   pix = 5'd9;
			5'd19:   pix = 5'd15;
			5'd20:   pix = 5'd19;
			5'd21:   pix = 5'd21;
			5'd22:   pix = 5'd23;
			5'd23:   pix = 5'd10;
			5'd24:   pix = 5'd14;
			default: pix = 5'd0;
		endcase
		return pix;
	endfunction

endpackage

>>> design/led_meter_gradient_painter.sv
// Top level of the LED meter gradient painter: run sequencer, slot stage, output register.
// Depends on lmgp_pkg and lmgp_blend.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall  | fill_level
//  out     | output    | out_valid / out_stall| pixel_address, pixel_rgb, run_end
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One input transaction yields 25 + min(fill_level, 25) output transactions, one per
// cycle while out_stall is low. The step counter sets that figure; the next item is
// taken in the cycle its predecessor's last step enters the pipe, so runs follow
// with no gap. Two stages (slot decode, blend into output register) move together
// and freeze while a result waits under out_stall. arst_n clears control state and
// loads the stop reset colors.
module led_meter_gradient_painter
	import lmgp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [LEVEL_W-1:0]   fill_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    pixel_address,
	output rgb_t                 pixel_rgb,
	output logic                 run_end,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  rgb_t                 cfg_data
);

	// gradient stops
	rgb_t stop0_q, stop1_q, stop2_q, stop3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop0_q <= STOP_ZERO_RST;
			stop1_q <= STOP_ONE_RST;
			stop2_q <= STOP_TWO_RST;
			stop3_q <= STOP_THREE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STOP_ZERO:  stop0_q <= cfg_data;
				REG_STOP_ONE:   stop1_q <= cfg_data;
				REG_STOP_TWO:   stop2_q <= cfg_data;
				REG_STOP_THREE: stop3_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// pipe moves when the output register is empty or being drained
	logic advance;
	assign advance = !out_valid || !out_stall;

	// run sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] final_q;
	logic              gen_fire;
	logic              gen_last;
	logic              in_fire;
	logic [LEVEL_W-1:0] level_sat;

	assign gen_fire  = busy_q && advance;
	assign gen_last  = (step_q == final_q);
	assign in_stall  = busy_q && !(advance && gen_last);
	assign in_fire   = in_valid && !in_stall;
	assign level_sat = (fill_level > LEVEL_MAX) ? LEVEL_MAX : fill_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			final_q <= '0;
		end else if (in_fire) begin
			busy_q  <= 1'b1;
			step_q  <= '0;
			final_q <= LAST_BLACK_STEP + level_sat[STEP_W-1:0];
		end else if (gen_fire) begin
			if (gen_last)
				busy_q <= 1'b0;
			step_q <= step_q + 6'd1;
		end
	end

	// slot decode: black phase uses a zero stop pair, slots pick segment and mix
	logic              is_slot;
	logic [ADDR_W-1:0] slot;
	logic [12:0]       slot_x255;
	logic [9:0]        pos;
	seg_t              seg;
	chan_t             mix_d;
	rgb_t              a_d, b_d;
	logic [ADDR_W-1:0] addr_d;

	assign is_slot   = (step_q > LAST_BLACK_STEP);
	assign slot      = 5'(step_q - STEP_W'(PIXEL_COUNT));
	assign slot_x255 = {slot, 8'd0} - 13'(slot);
	assign pos       = slot_x255[12:3];               // floor(s*765/24) = floor(s*255/8)

	always_comb begin
		if (slot == LAST_SLOT) begin
			seg   = SEG_END;
			mix_d = '0;
		end else if (pos >= 10'd510) begin
			seg   = SEG_HIGH;
			mix_d = 8'(pos - 10'd510);
		end else if (pos >= 10'd255) begin
			seg   = SEG_MID;
			mix_d = 8'(pos - 10'd255);
		end else begin
			seg   = SEG_LOW;
			mix_d = pos[7:0];
		end
	end

	always_comb begin
		case (seg)
			SEG_LOW:  begin a_d = stop0_q; b_d = stop1_q; end
			SEG_MID:  begin a_d = stop1_q; b_d = stop2_q; end
			SEG_HIGH: begin a_d = stop2_q; b_d = stop3_q; end
			SEG_END:  begin a_d = stop3_q; b_d = stop3_q; end
			default:  begin a_d = stop3_q; b_d = stop3_q; end
		endcase
	end

	assign addr_d = is_slot ? slot_to_pixel(slot) : step_q[ADDR_W-1:0];

	// stage 1
	logic              valid_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;
	chan_t             mix_s1;
	rgb_t              a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= gen_fire;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= gen_last;
			addr_s1 <= addr_d;
			mix_s1  <= is_slot ? mix_d : '0;
			a_s1    <= is_slot ? a_d : '0;
			b_s1    <= is_slot ? b_d : '0;
		end
	end

	// stage 2: blend into the output register
	rgb_t blend_rgb;

	lmgp_blend u_blend (
		.stop_a (a_s1),
		.stop_b (b_s1),
		.mix    (mix_s1),
		.rgb    (blend_rgb)
	);

	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	rgb_t              rgb_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_q <= addr_s1;
			rgb_q  <= blend_rgb;
			last_q <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_rgb     = rgb_q;
	assign run_end       = last_q;

endmodule

>>> design/lmgp_blend.sv
// Blends two gradient stops per channel: (a*(255-mix) + b*mix) / 255, floored.
// Pure combinational; three channel lanes side by side.
// Depends on lmgp_pkg.
module lmgp_blend
	import lmgp_pkg::*;
(
	input  rgb_t  stop_a,
	input  rgb_t  stop_b,
	input  chan_t mix,
	output rgb_t  rgb
);

	chan_t inv_mix;
	assign inv_mix = 8'd255 - mix;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [15:0] prod_a;
		logic [15:0] prod_b;
		logic [16:0] sum;
		logic [16:0] adj;

		assign prod_a = 16'(stop_a[c*CHAN_W +: CHAN_W]) * 16'(inv_mix);
		assign prod_b = 16'(stop_b[c*CHAN_W +: CHAN_W]) * 16'(mix);
		assign sum    = 17'(prod_a) + 17'(prod_b);
		// floor(v/255) for v < 2^16: (v + (v>>8) + 1) >> 8
		assign adj    = sum + 17'(sum[16:8]) + 17'd1;
		assign rgb[c*CHAN_W +: CHAN_W] = adj[15:8];
	end

endmodule
